### rtl/glpf_pkg.sv
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared types and constants for the grid local peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package glpf_pkg;

    localparam int CFG_BITS       = 7;
    localparam int CFG_ADDR_BITS  = 1;
    localparam int OUT_COORD_BITS = 6;
    localparam int OUT_TDATA_BITS = 16;
    localparam int GRID_SIZE_RESET = 64;

    localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

    // Result slots of one item, in output order
    localparam int RES_COUNT = 3;
    localparam int RES_UP    = 0;   // cell one row above
    localparam int RES_LEFT  = 1;   // cell one column back, last row
    localparam int RES_HERE  = 2;   // current cell, last row and column

    // Window cells: current row one and two columns back
    localparam int WIN_CELLS = 2;

    typedef struct packed {
        logic lt;   // held value below incoming value
        logic gt;   // held value above incoming value
    } cmp_t;

endpackage

`default_nettype wire

### rtl/glpf_ram.sv
// ----------------------------------------------------------------------------
// glpf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// Read returns the contents before a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module glpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/glpf_cell.sv
// ----------------------------------------------------------------------------
// glpf_cell
// One window cell: holds a value, shifts in its neighbor's value on enable
// and compares what it holds against the value arriving from that neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module glpf_cell #(
    parameter int WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic signed [WIDTH-1:0] d,
    output logic signed      [WIDTH-1:0] q,
    output glpf_pkg::cmp_t               cmp
);
    import glpf_pkg::*;

    logic signed [WIDTH-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= d;
        end
    end

    assign q      = value_reg;
    assign cmp.lt = value_reg < d;
    assign cmp.gt = value_reg > d;

endmodule

`default_nettype wire

### rtl/grid_local_peak_finder.sv
// ----------------------------------------------------------------------------
// grid_local_peak_finder
// Streams a signed grid in row-major order and reports the row and column of
// every cell that is >= each of its up, down, left and right neighbors.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                               Marker
// s_axis    in   tdata: cell_value                     -
// m_axis    out  tdata: peak_row[5:0], peak_col[11:6]  tlast: last_of_run
// cfg       in   index 0 grid_width, 1 grid_height     write enable only
//
// An item is taken every cycle while each item yields at most one result and
// the output is not stalled; an item with several results offers them one at
// a time, and the input stalls until only its last result remains.
// An item is registered in the evaluation stage, then its results in the output stage.
// Line store is a RAM with one read and one write per item; no clearing pass.
// Reset sets both sizes to 64 and the position to row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_local_peak_finder #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // cell_value
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // peak_row, peak_col
    output logic      [glpf_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
    output logic                                         m_axis_tlast,
    input  wire logic                                    cfg_we,
    input  wire logic [glpf_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
    input  wire logic [glpf_pkg::CFG_BITS-1:0]           cfg_wdata
);
    import glpf_pkg::*;

    localparam int ColBits   = $clog2(MAX_WIDTH);
    localparam int RowBits   = $clog2(MAX_HEIGHT);
    localparam int WSizeBits = (ColBits + 1 > CFG_BITS) ? ColBits + 1 : CFG_BITS;
    localparam int HSizeBits = (RowBits + 1 > CFG_BITS) ? RowBits + 1 : CFG_BITS;

    // configuration
    logic [CFG_BITS-1:0]  grid_width_reg, grid_height_reg;
    logic [WSizeBits-1:0] width_cfg, width_eff;
    logic [HSizeBits-1:0] height_cfg, height_eff;

    // position
    logic [ColBits-1:0] col_reg, col_next, in_col;
    logic [RowBits-1:0] row_reg, row_next, in_row;
    logic               pos_wrap, in_last_col, in_last_row, s_accept;
    logic signed [VALUE_BITS-1:0] in_value;

    // evaluation stage
    logic                         ev_valid_reg, ev_valid_next, ev_advance;
    logic signed [VALUE_BITS-1:0] ev_val_reg, up_value, win_up_reg;
    logic [ColBits-1:0]           ev_col_reg;
    logic [RowBits-1:0]           ev_row_reg;
    logic                         ev_last_row_reg, ev_last_col_reg;
    logic                         ev_has_up, ev_has_left, ev_has_left2;
    logic                         left_ok, right_ok;
    logic                         hit_up, hit_left, hit_here;
    logic [MAX_WIDTH-1:0]         cand_reg, cand_next;

    logic signed [VALUE_BITS-1:0] win_d [WIN_CELLS];
    logic signed [VALUE_BITS-1:0] win_q [WIN_CELLS];
    cmp_t                         win_cmp [WIN_CELLS];

    // output stage
    logic [RES_COUNT-1:0]      out_mask_reg, out_mask_next;
    logic [ColBits-1:0]        out_col_reg;
    logic [RowBits-1:0]        out_row_reg;
    logic                      out_single, out_load_ok, out_pop;
    logic [ColBits-1:0]        sel_col;
    logic [RowBits-1:0]        sel_row;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= CFG_BITS'(GRID_SIZE_RESET);
            grid_height_reg <= CFG_BITS'(GRID_SIZE_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign width_cfg  = WSizeBits'(grid_width_reg);
    assign height_cfg = HSizeBits'(grid_height_reg);

    // zero counts as one, oversize clamps to the maximum
    always_comb begin
        if (width_cfg == '0) begin
            width_eff = WSizeBits'(1);
        end else if (width_cfg > WSizeBits'(MAX_WIDTH)) begin
            width_eff = WSizeBits'(MAX_WIDTH);
        end else begin
            width_eff = width_cfg;
        end
        if (height_cfg == '0) begin
            height_eff = HSizeBits'(1);
        end else if (height_cfg > HSizeBits'(MAX_HEIGHT)) begin
            height_eff = HSizeBits'(MAX_HEIGHT);
        end else begin
            height_eff = height_cfg;
        end
    end

    // ---------------- input position ----------------
    assign pos_wrap    = (WSizeBits'(col_reg) >= width_eff) ||
                         (HSizeBits'(row_reg) >= height_eff);
    assign in_col      = pos_wrap ? '0 : col_reg;
    assign in_row      = pos_wrap ? '0 : row_reg;
    assign in_last_col = WSizeBits'(in_col) == (width_eff - WSizeBits'(1));
    assign in_last_row = HSizeBits'(in_row) == (height_eff - HSizeBits'(1));
    assign in_value    = s_axis_tdata[VALUE_BITS-1:0];
    assign s_accept    = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (in_last_col) begin
                col_next = '0;
                row_next = in_last_row ? '0 : in_row + RowBits'(1);
            end else begin
                col_next = in_col + ColBits'(1);
                row_next = in_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line store ----------------
    glpf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (in_col),
        .wr_data (in_value),
        .rd_en   (s_accept),
        .rd_addr (in_col),
        .rd_data (up_value)
    );

    // ---------------- evaluation stage ----------------
    assign s_axis_tready = !ev_valid_reg || out_load_ok;
    assign ev_advance    = ev_valid_reg && out_load_ok;

    always_comb begin
        ev_valid_next = ev_valid_reg;
        if (s_accept) begin
            ev_valid_next = 1'b1;
        end else if (ev_advance) begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
        end else begin
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ev_val_reg      <= in_value;
            ev_col_reg      <= in_col;
            ev_row_reg      <= in_row;
            ev_last_col_reg <= in_last_col;
            ev_last_row_reg <= in_last_row;
        end
        if (ev_advance) begin
            win_up_reg <= up_value;
        end
    end

    // window chain: cell 0 holds one column back, cell 1 two columns back
    always_comb begin
        for (int i = 0; i < WIN_CELLS; i++) begin
            win_d[i] = (i == 0) ? ev_val_reg : win_q[(i == 0) ? 0 : i - 1];
        end
    end

    for (genvar g = 0; g < WIN_CELLS; g++) begin : g_win
        glpf_cell #(
            .WIDTH (VALUE_BITS)
        ) u_cell (
            .aclk (aclk),
            .en   (ev_advance),
            .d    (win_d[g]),
            .q    (win_q[g]),
            .cmp  (win_cmp[g])
        );
    end

    assign ev_has_up    = ev_row_reg != '0;
    assign ev_has_left  = ev_col_reg != '0;
    assign ev_has_left2 = ev_col_reg > ColBits'(1);

    assign left_ok  = ev_has_left && !win_cmp[0].lt &&
                      !(ev_has_left2 && win_cmp[1].gt) &&
                      !(ev_has_up && (win_up_reg > win_q[0]));
    assign right_ok = !(ev_has_left && win_cmp[0].gt) &&
                      !(ev_has_up && (ev_val_reg < up_value));

    assign hit_up   = ev_has_up && cand_reg[ev_col_reg] && (up_value >= ev_val_reg);
    assign hit_left = ev_last_row_reg && left_ok;
    assign hit_here = ev_last_row_reg && ev_last_col_reg && right_ok;

    // candidates are >= their up, left and right neighbors; settled by the row below
    always_comb begin
        cand_next = cand_reg;
        if (ev_advance && !ev_last_row_reg) begin
            if (ev_has_left) begin
                cand_next[ev_col_reg - ColBits'(1)] = left_ok;
            end
            if (ev_last_col_reg) begin
                cand_next[ev_col_reg] = right_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '0;
        end else begin
            cand_reg <= cand_next;
        end
    end

    // ---------------- output stage ----------------
    assign out_single  = (out_mask_reg & (out_mask_reg - RES_COUNT'(1))) == '0;
    assign out_load_ok = (out_mask_reg == '0) || (out_single && m_axis_tready);
    assign out_pop     = m_axis_tvalid && m_axis_tready;

    always_comb begin
        out_mask_next = out_mask_reg;
        if (ev_advance) begin
            out_mask_next[RES_UP]   = hit_up;
            out_mask_next[RES_LEFT] = hit_left;
            out_mask_next[RES_HERE] = hit_here;
        end else if (out_pop) begin
            out_mask_next = out_mask_reg & (out_mask_reg - RES_COUNT'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_mask_reg <= '0;
        end else begin
            out_mask_reg <= out_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_advance) begin
            out_col_reg <= ev_col_reg;
            out_row_reg <= ev_row_reg;
        end
    end

    always_comb begin
        sel_col = out_col_reg;
        sel_row = out_row_reg;
        if (out_mask_reg[RES_UP]) begin
            sel_row = out_row_reg - RowBits'(1);
        end else if (out_mask_reg[RES_LEFT]) begin
            sel_col = out_col_reg - ColBits'(1);
        end
    end

    assign m_axis_tvalid = out_mask_reg != '0;
    assign m_axis_tlast  = out_single;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS - 2*OUT_COORD_BITS){1'b0}},
                            OUT_COORD_BITS'(sel_col),
                            OUT_COORD_BITS'(sel_row)};

endmodule

`default_nettype wire
